### rtl/tpid_pkg.sv
// Package: widths, register indexes, control word layout and microcode ROM for the throttle PID.
`timescale 1ns / 1ps

package tpid_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int FRAC_W        = 17;
  localparam int THR_W         = 14;
  localparam int CFG_IDX_W     = 3;
  localparam int PC_W          = 3;

  localparam logic [FRAC_W-1:0] MAX_THROTTLE_RST = 17'd65536;
  localparam logic [THR_W-1:0]  WINDUP_THR_RST   = 14'd2500;
  localparam logic [FRAC_W-1:0] INTEG_LIMIT_RST  = 17'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN      = 3'd0,
    CFG_I_GAIN      = 3'd1,
    CFG_D_GAIN      = 3'd2,
    CFG_NOMINAL     = 3'd3,
    CFG_MIN_THR     = 3'd4,
    CFG_MAX_THR     = 3'd5,
    CFG_WINDUP_THR  = 3'd6,
    CFG_INTEG_LIMIT = 3'd7
  } cfg_idx_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_DIFF  = 3'd1;
  localparam logic [PC_W-1:0] PC_INTEG = 3'd2;
  localparam logic [PC_W-1:0] PC_PTERM = 3'd3;
  localparam logic [PC_W-1:0] PC_DTERM = 3'd4;
  localparam logic [PC_W-1:0] PC_ITERM = 3'd5;
  localparam logic [PC_W-1:0] PC_OUT   = 3'd6;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_WAIT_IN  = 2'd1,
    SEQ_WAIT_OUT = 2'd2
  } seq_t;

  typedef enum logic [1:0] {
    MA_P = 2'd0,
    MA_I = 2'd1,
    MA_D = 2'd2
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_ERR   = 2'd0,
    MB_DERR  = 2'd1,
    MB_INTEG = 2'd2
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD     = 2'd0,
    ACC_LOAD_NOM = 2'd1,
    ACC_ADD      = 2'd2
  } acc_op_t;

  typedef struct packed {
    seq_t    seq;
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    logic    err_ld;
    logic    derr_ld;
    logic    integ_ld;
    acc_op_t acc_op;
    logic    out_ld;
  } uop_t;

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u        = '0;
    u.seq    = SEQ_NEXT;
    u.mul_a  = MA_P;
    u.mul_b  = MB_ERR;
    u.acc_op = ACC_HOLD;
    case (pc)
      PC_IDLE: begin
        u.seq    = SEQ_WAIT_IN;
        u.err_ld = 1'b1;
      end
      PC_DIFF: begin
        u.derr_ld = 1'b1;
        u.mul_en  = 1'b1;
        u.mul_a   = MA_I;
        u.mul_b   = MB_ERR;
      end
      PC_INTEG: begin
        u.integ_ld = 1'b1;
        u.mul_en   = 1'b1;
        u.mul_a    = MA_P;
        u.mul_b    = MB_ERR;
        u.acc_op   = ACC_LOAD_NOM;
      end
      PC_PTERM: begin
        u.acc_op = ACC_ADD;
        u.mul_en = 1'b1;
        u.mul_a  = MA_D;
        u.mul_b  = MB_DERR;
      end
      PC_DTERM: begin
        u.acc_op = ACC_ADD;
        u.mul_en = 1'b1;
        u.mul_a  = MA_I;
        u.mul_b  = MB_INTEG;
      end
      PC_ITERM: begin
        u.acc_op = ACC_ADD;
      end
      PC_OUT: begin
        u.seq    = SEQ_WAIT_OUT;
        u.out_ld = 1'b1;
      end
      default: begin
        u.seq = SEQ_WAIT_OUT;
      end
    endcase
    return u;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/throttle_pid_with_windup_reset.sv
// Top level: microcoded throttle PID with integrator clamp and windup reset.
`timescale 1ns / 1ps

// Usage
//   Input channel in_*: one word per control tick (target, measured, setpoint).
//   Output channel out_*: one word per input word (clamped throttle, error).
//   Both channels: a word moves on a rising edge with valid high and stall low.
//   cfg_*: write gains and limits while no word is in flight; index picks the register.
// Timing
//   Each word passes the accept cycle and six microcode steps, which use
//   one shared 32x32 multiplier (four products, each registered before use).
//   The result is registered in the last step; the next word can be taken
//   in the cycle after that, even while the result still waits downstream.
// Reset
//   rst_n low clears the sequencer, the output valid, previous error and
//   integrator, and loads the register defaults.
// Stall
//   A stalled result holds its word; the sequencer holds at its last step
//   until the output register is free, and in_stall stays high meanwhile.
module throttle_pid_with_windup_reset
  import tpid_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_target_position,
  input  logic signed [DATA_W-1:0] in_measured_position,
  input  logic [THR_W-1:0]         in_throttle_setpoint,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FRAC_W-1:0]        out_cruise_throttle,
  output logic signed [DATA_W-1:0] out_position_error
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = TERM_W + 2;

  logic signed [DATA_W-1:0] p_gain_r, i_gain_r, d_gain_r;
  logic [FRAC_W-1:0]        nominal_r, min_thr_r, max_thr_r, ilim_r;
  logic [THR_W-1:0]         thr_r;

  logic [PC_W-1:0]          pc_r, pc_nxt;
  uop_t                     uop;

  logic signed [DATA_W-1:0] err_r, derr_r, prev_r, integ_r, integ_nxt;
  logic [THR_W-1:0]         setp_r;
  logic signed [PROD_W-1:0] prod_r, mul_full;
  logic signed [DATA_W-1:0] mul_a_s, mul_b_s;
  logic signed [TERM_W-1:0] term;
  logic signed [TERM_W:0]   integ_sum, lim_pos, lim_neg;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, max_ext, min_ext;
  logic [FRAC_W-1:0]        cruise;

  logic                     in_acc, out_free, out_fire;
  logic                     out_valid_r;
  logic [FRAC_W-1:0]        out_cruise_r;
  logic signed [DATA_W-1:0] out_err_r;

  assign uop      = ucode(pc_r);
  assign in_stall = (pc_r != PC_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_fire = uop.out_ld && out_free;

  assign out_valid           = out_valid_r;
  assign out_cruise_throttle = out_cruise_r;
  assign out_position_error  = out_err_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r  <= '0;
      i_gain_r  <= '0;
      d_gain_r  <= '0;
      nominal_r <= '0;
      min_thr_r <= '0;
      max_thr_r <= MAX_THROTTLE_RST;
      thr_r     <= WINDUP_THR_RST;
      ilim_r    <= INTEG_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_P_GAIN:      p_gain_r  <= cfg_wdata;
        CFG_I_GAIN:      i_gain_r  <= cfg_wdata;
        CFG_D_GAIN:      d_gain_r  <= cfg_wdata;
        CFG_NOMINAL:     nominal_r <= cfg_wdata[FRAC_W-1:0];
        CFG_MIN_THR:     min_thr_r <= cfg_wdata[FRAC_W-1:0];
        CFG_MAX_THR:     max_thr_r <= cfg_wdata[FRAC_W-1:0];
        CFG_WINDUP_THR:  thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_INTEG_LIMIT: ilim_r    <= cfg_wdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    pc_nxt = pc_r;
    case (uop.seq)
      SEQ_WAIT_IN:  if (in_acc) pc_nxt = pc_r + 1'b1;
      SEQ_WAIT_OUT: if (out_free) pc_nxt = PC_IDLE;
      default:      pc_nxt = pc_r + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // shared multiplier
  always_comb begin
    unique case (uop.mul_a)
      MA_I:    mul_a_s = i_gain_r;
      MA_D:    mul_a_s = d_gain_r;
      default: mul_a_s = p_gain_r;
    endcase
    unique case (uop.mul_b)
      MB_DERR:  mul_b_s = derr_r;
      MB_INTEG: mul_b_s = integ_r;
      default:  mul_b_s = err_r;
    endcase
  end

  assign mul_full = mul_a_s * mul_b_s;
  assign term     = TERM_W'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (uop.mul_en) begin
      prod_r <= mul_full;
    end
  end

  // integrator update
  assign integ_sum = {{(TERM_W+1-DATA_W){integ_r[DATA_W-1]}}, integ_r}
                   + {term[TERM_W-1], term};
  assign lim_pos   = {{(TERM_W+1-FRAC_W){1'b0}}, ilim_r};
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (setp_r < thr_r) begin
      integ_nxt = '0;
    end else if (integ_sum > lim_pos) begin
      integ_nxt = lim_pos[DATA_W-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_nxt = lim_neg[DATA_W-1:0];
    end else begin
      integ_nxt = integ_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else begin
      if (uop.derr_ld) begin
        prev_r <= err_r;
      end
      if (uop.integ_ld) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uop.err_ld && in_acc) begin
      err_r  <= sat_wide({in_target_position[DATA_W-1], in_target_position}
                       - {in_measured_position[DATA_W-1], in_measured_position});
      setp_r <= in_throttle_setpoint;
    end
    if (uop.derr_ld) begin
      derr_r <= sat_wide({err_r[DATA_W-1], err_r} - {prev_r[DATA_W-1], prev_r});
    end
  end

  // output sum and clamp
  always_comb begin
    case (uop.acc_op)
      ACC_LOAD_NOM: acc_nxt = {{(ACC_W-FRAC_W){1'b0}}, nominal_r};
      ACC_ADD:      acc_nxt = acc_r + {{2{term[TERM_W-1]}}, term};
      default:      acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign max_ext = {{(ACC_W-FRAC_W){1'b0}}, max_thr_r};
  assign min_ext = {{(ACC_W-FRAC_W){1'b0}}, min_thr_r};

  always_comb begin
    if (acc_r > max_ext) begin
      cruise = max_thr_r;
    end else if (acc_r < min_ext) begin
      cruise = min_thr_r;
    end else begin
      cruise = acc_r[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_cruise_r <= cruise;
      out_err_r    <= err_r;
    end
  end

  a_out_from_last_step : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == PC_OUT)
    else $error("output word raised outside the last step");

  a_accept_starts_program : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pc_r == PC_DIFF)
    else $error("accepted word did not start the program");

  a_steps_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != PC_IDLE && pc_r != PC_OUT) |=> pc_r == PC_W'($past(pc_r) + 1'b1))
    else $error("microcode step did not advance");

  a_cruise_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && min_thr_r <= max_thr_r)
      |-> (out_cruise_r <= max_thr_r && out_cruise_r >= min_thr_r))
    else $error("cruise throttle outside clamp range");

endmodule

### bench/throttle_pid_checker.sv
// Checker: mirrors the throttle PID registers and state, predicts each result word and compares.
`timescale 1ns / 1ps

module throttle_pid_checker
  import tpid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_target_position,
  input  logic signed [DATA_W-1:0] in_measured_position,
  input  logic [THR_W-1:0]         in_throttle_setpoint,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [FRAC_W-1:0]        out_cruise_throttle,
  input  logic signed [DATA_W-1:0] out_position_error,
  output int                       fail_count,
  output int                       pending
);

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct {
    logic [FRAC_W-1:0]        throttle;
    logic signed [DATA_W-1:0] error;
  } throttle_word_t;

  longint kp, ki, kd;
  longint nominal, min_thr, max_thr, windup, limit;
  longint prev_err, integ;

  throttle_word_t throttle_due[$];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint prod;
    prod = a * b;
    return prod >>> FRAC;
  endfunction

  function automatic throttle_word_t next_throttle(input longint tgt, input longint meas,
                                                   input longint sp);
    longint err, derr, acc, cruise;
    throttle_word_t w;
    err      = clip32(tgt - meas);
    derr     = clip32(err - prev_err);
    prev_err = err;
    acc = integ + qmul(ki, err);
    if (sp < windup) acc = 0;
    if (acc > limit) acc = limit;
    else if (acc < -limit) acc = -limit;
    integ  = acc;
    cruise = nominal + qmul(kp, err) + qmul(ki, integ) + qmul(kd, derr);
    if (cruise > max_thr) cruise = max_thr;
    else if (cruise < min_thr) cruise = min_thr;
    w.throttle = cruise[FRAC_W-1:0];
    w.error    = err[DATA_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    throttle_word_t w;
    if (!rst_n) begin
      kp       = 0;
      ki       = 0;
      kd       = 0;
      nominal  = 0;
      min_thr  = 0;
      max_thr  = longint'(MAX_THROTTLE_RST);
      windup   = longint'(WINDUP_THR_RST);
      limit    = longint'(INTEG_LIMIT_RST);
      prev_err = 0;
      integ    = 0;
      throttle_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_P_GAIN:      kp      = longint'($signed(cfg_wdata));
          CFG_I_GAIN:      ki      = longint'($signed(cfg_wdata));
          CFG_D_GAIN:      kd      = longint'($signed(cfg_wdata));
          CFG_NOMINAL:     nominal = longint'(cfg_wdata[FRAC_W-1:0]);
          CFG_MIN_THR:     min_thr = longint'(cfg_wdata[FRAC_W-1:0]);
          CFG_MAX_THR:     max_thr = longint'(cfg_wdata[FRAC_W-1:0]);
          CFG_WINDUP_THR:  windup  = longint'(cfg_wdata[THR_W-1:0]);
          CFG_INTEG_LIMIT: limit   = longint'(cfg_wdata[FRAC_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        throttle_due.push_back(next_throttle(longint'(in_target_position),
                                             longint'(in_measured_position),
                                             longint'(in_throttle_setpoint)));
      end
      if (out_valid && !out_stall) begin
        if (throttle_due.size() == 0) begin
          $display("%0t: unexpected result word cruise_throttle %0d position_error %0d",
                   $time, out_cruise_throttle, out_position_error);
          fail_count++;
        end else begin
          w = throttle_due.pop_front();
          if (out_cruise_throttle !== w.throttle) begin
            $display("%0t: cruise_throttle expected %0d actual %0d",
                     $time, w.throttle, out_cruise_throttle);
            fail_count++;
          end
          if (out_position_error !== w.error) begin
            $display("%0t: position_error expected %0d actual %0d",
                     $time, w.error, out_position_error);
            fail_count++;
          end
        end
      end
    end
    pending = throttle_due.size();
  end

endmodule

### bench/tb_throttle_pid_with_windup_reset.sv
// Testbench top: drives ticks, gains and back-pressure into the throttle PID and gives the verdict.
`timescale 1ns / 1ps

module tb_throttle_pid_with_windup_reset;
  import tpid_pkg::*;

  localparam int LATENCY     = 7;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_TICKS = 155;

  localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] NEG_MAX = 32'sh8000_0000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_target_position = '0;
  logic signed [DATA_W-1:0] in_measured_position = '0;
  logic [THR_W-1:0]         in_throttle_setpoint = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [FRAC_W-1:0]        out_cruise_throttle;
  logic signed [DATA_W-1:0] out_position_error;

  int  fail_count;
  int  pending;
  int  tx_odds = 0;
  int  rx_odds = 0;
  int  rx_gap_left = 0;
  int  rx_hold_left = 0;
  int  quiet = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  logic [DATA_W-1:0] reg_val [8];
  longint windup_now = 2500;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  throttle_pid_with_windup_reset u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_position  (in_target_position),
    .in_measured_position(in_measured_position),
    .in_throttle_setpoint(in_throttle_setpoint),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cruise_throttle (out_cruise_throttle),
    .out_position_error  (out_position_error)
  );

  throttle_pid_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_target_position  (in_target_position),
    .in_measured_position(in_measured_position),
    .in_throttle_setpoint(in_throttle_setpoint),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cruise_throttle (out_cruise_throttle),
    .out_position_error  (out_position_error),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // receiver: random stall bursts, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_stall    <= 1'b1;
      rx_hold_left <= LONG_HOLD - 1;
      hold_done    <= 1'b1;
    end else if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_gap_left > 0) begin
      out_stall   <= 1'b1;
      rx_gap_left <= rx_gap_left - 1;
    end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      out_stall   <= 1'b1;
      rx_gap_left <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic program_regs();
    cfg_idx_t r;
    r = r.first();
    do begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= reg_val[r];
      r = r.next();
    end while (r != r.first());
    @(negedge clk);
    cfg_we <= 1'b0;
    windup_now = longint'(reg_val[CFG_WINDUP_THR][THR_W-1:0]);
  endtask

  task automatic set_regs(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                          input logic [31:0] nom, input logic [31:0] mn,
                          input logic [31:0] mx, input logic [31:0] wt,
                          input logic [31:0] lim);
    reg_val[CFG_P_GAIN]      = p;
    reg_val[CFG_I_GAIN]      = i;
    reg_val[CFG_D_GAIN]      = d;
    reg_val[CFG_NOMINAL]     = nom;
    reg_val[CFG_MIN_THR]     = mn;
    reg_val[CFG_MAX_THR]     = mx;
    reg_val[CFG_WINDUP_THR]  = wt;
    reg_val[CFG_INTEG_LIMIT] = lim;
    program_regs();
  endtask

  function automatic logic [31:0] rand_gain(input int bits);
    return 32'(int'($urandom_range(0, 1 << bits)) - (1 << (bits - 1)));
  endfunction

  task automatic send_tick(input logic signed [DATA_W-1:0] tgt,
                           input logic signed [DATA_W-1:0] meas,
                           input logic [THR_W-1:0] sp);
    int gap;
    @(negedge clk);
    if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_target_position   <= tgt;
    in_measured_position <= meas;
    in_throttle_setpoint <= sp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_tick();
    logic signed [DATA_W-1:0] meas;
    logic signed [DATA_W-1:0] tgt;
    logic [THR_W-1:0]         sp;
    int                       pick;
    pick = $urandom_range(0, 9);
    meas = $urandom();
    if (pick < 5) tgt = meas + (int'($urandom_range(0, 1 << 15)) - (1 << 14));
    else if (pick < 7) tgt = meas + (int'($urandom_range(0, 1 << 25)) - (1 << 24));
    else if (pick == 7) tgt = meas;
    else tgt = $urandom();
    if ($urandom_range(0, 3) != 0 && windup_now <= 9600)
      sp = THR_W'($urandom_range(int'(windup_now), 9600));
    else
      sp = THR_W'($urandom_range(0, 16383));
    send_tick(tgt, meas, sp);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    tx_odds = 6;
    rx_odds = 6;
    set_regs(32'd65536, 32'd32768, 32'd16384, 32'd32768, 32'd0, 32'd65536, 32'd2500, 32'd3277);
    send_tick(0, 0, 14'd0);
    send_tick(POS_MAX, NEG_MAX, 14'd9600);
    send_tick(NEG_MAX, POS_MAX, 14'd9600);
    send_tick(POS_MAX, NEG_MAX, 14'd9600);
    send_tick(32'sd65536, 0, 14'd2499);
    send_tick(32'sd65536, 0, 14'd2500);
    send_tick(-32'sd65536, 0, 14'h3FFF);
    repeat (3) send_tick(32'sd131072, 0, 14'd5000);
    repeat (3) send_tick(-32'sd196608, 0, 14'd5000);
    send_tick(-32'sd1, 0, 14'd9600);
    send_tick(32'sd1, 0, 14'd9600);
    send_tick(POS_MAX, POS_MAX, 14'd0);
    send_tick(NEG_MAX, NEG_MAX, 14'd9600);
    drain();

    // lower clamp above upper clamp
    set_regs(32'd65536, 32'd0, 32'd0, 32'd32768, 32'd60000, 32'd1000, 32'd0, 32'd3277);
    send_tick(0, 0, 14'd100);
    send_tick(-32'sd1048576, 0, 14'd100);
    send_tick(-32'sd32000, 0, 14'd100);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      tx_odds = $urandom_range(2, 8);
      rx_odds = $urandom_range(2, 8);
      case (ph)
        1: set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd65536,
                    32'd0, 32'd65536);
        2: set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd65536, 32'd0, 32'd0,
                    32'd9600, 32'd0);
        4: set_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
        5: set_regs(32'd0, rand_gain(16), 32'd0, 32'd65536, 32'd65536, 32'd65536,
                    32'd9600, 32'd65536);
        default: set_regs(rand_gain(19), rand_gain(16), rand_gain(19),
                          $urandom_range(0, 65536), $urandom_range(0, 16384),
                          $urandom_range(32768, 65536), $urandom_range(0, 9600),
                          $urandom_range(0, 65536));
      endcase
      if (ph == 6) tx_odds = 0;
      if (ph == N_PHASES - 1) begin
        tx_odds = 0;
        rx_odds = 0;
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        random_tick();
        if (ph == 3 && n == 30) hold_req = 1'b1;
      end
      drain();
    end

    repeat (LATENCY * 2) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### throttle_pid_with_windup_reset.f
rtl/tpid_pkg.sv
rtl/throttle_pid_with_windup_reset.sv
bench/throttle_pid_checker.sv
bench/tb_throttle_pid_with_windup_reset.sv
